// ----- rtl/core/spsg_pkg.sv -----
package spsg_pkg;

    localparam int COUNTER_BITS = 16;
    localparam logic [COUNTER_BITS-1:0] CMAX = '1;

    localparam int CLK_W      = 32;
    localparam int FREQ_W     = 32;
    localparam int STEPS_W    = 16;
    localparam int PW_W       = 16;
    localparam int SWEEP_W    = STEPS_W + 1;
    localparam int OUT_W      = 16;
    localparam int MULT_W     = 10;
    localparam int NUM_W      = CLK_W + MULT_W;
    localparam int DEN_W      = (COUNTER_BITS + 1 > FREQ_W) ? COUNTER_BITS + 1 : FREQ_W;
    localparam int CMP_W      = (PW_W + 1 > COUNTER_BITS) ? PW_W + 1 : COUNTER_BITS;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    localparam int OP_W       = 2;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CLK_W-1:0]   CLOCK_RESET = 32'd64000000;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd80;
    localparam logic [PW_W-1:0]    WIDTH_RESET = 16'd100;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_SET_FREQ   = 2'd1,
        OP_SET_TRACK  = 2'd2,
        OP_TRACK_ZERO = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK = 2'd0,
        CFG_STEPS = 2'd1,
        CFG_WIDTH = 2'd2,
        CFG_ZERO  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DSEL_RAW = 2'd0,
        DSEL_PRE = 2'd1,
        DSEL_PER = 2'd2,
        DSEL_WID = 2'd3
    } dsel_t;

    typedef struct packed {
        logic  busy;
        logic  div_start;
        dsel_t div_sel;
    } spsg_cmd_t;

    typedef struct packed {
        logic freq_start;
        logic div_done;
    } spsg_sts_t;

endpackage

// ----- rtl/core/step_pulse_sweep_generator_top.sv -----
// Tick, set-track, track-zero and zero-frequency items: result registered in the pending flag, then in the
// output register; one item per cycle while the result side keeps up and no frequency setup is running.
// Set frequency (nonzero): three 42-step divisions on the shared restoring divider and a prescaler
// step after the first one; no other item is accepted until the last division is done.
// Reset (aresetn low, synchronous): output stopped, counters and limits zero,
// configuration registers at their defaults, no result pending.
module step_pulse_sweep_generator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spsg_pkg::S_DATA_W-1:0]   s_tdata,   // freq_millihz[31:0], track_value[48:32]
    input  logic [spsg_pkg::OP_W-1:0]       s_tuser,   // operation[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spsg_pkg::M_DATA_W-1:0]   m_tdata,   // step_out[0], direction[1], track[17:2],
                                                       // prescale_value[33:18], period_value[49:34],
                                                       // compare_value[65:50], running[66]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spsg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import spsg_pkg::*;

    spsg_cmd_t cmd;
    spsg_sts_t sts;

    spsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    spsg_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- rtl/core/spsg_div.sv -----
module spsg_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [spsg_pkg::NUM_W-1:0] dividend,
    input  logic [spsg_pkg::DEN_W-1:0] divisor,
    output logic                      done,
    output logic [spsg_pkg::NUM_W-1:0] quotient
);
    import spsg_pkg::*;

    logic [NUM_W-1:0]     quo_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && (cnt_reg == DIV_CNT_W'(1));
            if (start) begin
                cnt_reg <= DIV_CNT_W'(NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/spsg_datapath.sv -----
module spsg_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spsg_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [spsg_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spsg_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spsg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  spsg_pkg::spsg_cmd_t             cmd,
    output spsg_pkg::spsg_sts_t             sts
);
    import spsg_pkg::*;

    localparam int CB = COUNTER_BITS;

    function automatic logic [CB-1:0] sat(input logic [NUM_W-1:0] q);
        return (q > NUM_W'(CMAX)) ? CMAX : q[CB-1:0];
    endfunction

    logic [CLK_W-1:0]   clock_reg;
    logic [STEPS_W-1:0] steps_reg;
    logic [PW_W-1:0]    width_reg;
    logic               zero_reg;

    logic [CB-1:0]      pcount_reg;
    logic [CB-1:0]      tcount_reg;
    logic [SWEEP_W-1:0] sweep_reg;
    logic [CB-1:0]      prescale_reg;
    logic [CB-1:0]      period_reg;
    logic [CB-1:0]      compare_reg;
    logic               active_reg;

    logic [FREQ_W-1:0]  freq_reg;
    logic [NUM_W-1:0]   raw_reg;
    logic [CB-1:0]      pre_reg;
    logic [CB-1:0]      per_reg;

    logic               pend_reg;
    logic               mvalid_reg;
    logic [M_DATA_W-1:0] mdata_reg;

    op_t                op;
    logic [FREQ_W-1:0]  in_freq;
    logic [SWEEP_W-1:0] in_track;
    logic               accept;
    logic               copy;
    logic               commit;

    logic               div_done;
    logic [NUM_W-1:0]   quo;
    logic [NUM_W-1:0]   dvd;
    logic [DEN_W-1:0]   dvs;
    logic [DEN_W-1:0]   pre_inc;
    logic [NUM_W-1:0]   clk_ext;

    logic [NUM_W-1:0]   raw_hi;
    logic [NUM_W-1:0]   raw_sum;
    logic               raw_big;
    logic [CB-1:0]      pre_calc;

    logic [CMP_W-1:0]   wid_c;
    logic [CMP_W-1:0]   per_c;
    logic [CB-1:0]      cmp_new;

    logic [SWEEP_W:0]   sweep_inc;
    logic [SWEEP_W-1:0] sweep_lim;
    logic [SWEEP_W-1:0] sweep_adv;
    logic [SWEEP_W-1:0] trk_full;
    logic               step_out;
    logic               direction;

    assign op       = op_t'(s_tuser);
    assign in_freq  = s_tdata[FREQ_W-1:0];
    assign in_track = s_tdata[FREQ_W+SWEEP_W-1:FREQ_W];

    assign copy     = pend_reg && (!mvalid_reg || m_tready);
    assign s_tready = !cmd.busy && (!pend_reg || copy);
    assign accept   = s_tvalid && s_tready;
    assign commit   = div_done && (cmd.div_sel == DSEL_WID);

    assign sts.freq_start = accept && (op == OP_SET_FREQ) && (in_freq != '0);
    assign sts.div_done   = div_done;

    assign cfg_ready = 1'b1;

    always_comb begin
        clk_ext = NUM_W'(clock_reg);
        pre_inc = DEN_W'(pre_reg) + DEN_W'(1);
        case (cmd.div_sel)
            DSEL_RAW: begin
                dvd = (clk_ext << 10) - (clk_ext << 5) + (clk_ext << 3);
                dvs = DEN_W'(freq_reg);
            end
            DSEL_PER: begin
                dvd = raw_reg;
                dvs = pre_inc;
            end
            DSEL_WID: begin
                dvd = NUM_W'(width_reg);
                dvs = pre_inc;
            end
            default: begin
                dvd = raw_reg;
                dvs = pre_inc;
            end
        endcase
    end

    spsg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    // divide by CMAX: the high half falls short of the quotient by at most one
    always_comb begin
        raw_hi   = raw_reg >> CB;
        raw_sum  = NUM_W'(raw_reg[CB-1:0]) + raw_hi;
        raw_big  = ({CB'(0), raw_reg} >= ({NUM_W'(0), CMAX} << CB));
        pre_calc = raw_big ? CMAX
                           : (raw_hi[CB-1:0] + CB'(raw_sum >= NUM_W'(CMAX)));
    end

    always_comb begin
        wid_c   = CMP_W'(quo[PW_W-1:0]) + CMP_W'(1);
        per_c   = CMP_W'(per_reg);
        cmp_new = (wid_c < per_c) ? wid_c[CB-1:0] : (per_reg >> 1) + CB'(1);
    end

    always_comb begin
        sweep_inc = {1'b0, sweep_reg} + (SWEEP_W+1)'(1);
        sweep_lim = {steps_reg, 1'b0};
        sweep_adv = (sweep_inc >= {1'b0, sweep_lim}) ? '0 : sweep_inc[SWEEP_W-1:0];
        trk_full  = (sweep_reg > SWEEP_W'(steps_reg)) ? (sweep_lim - sweep_reg) : sweep_reg;
        direction = (sweep_reg >= SWEEP_W'(steps_reg));
        step_out  = active_reg && (tcount_reg < compare_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg <= CLOCK_RESET;
            steps_reg <= STEPS_RESET;
            width_reg <= WIDTH_RESET;
            zero_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CLOCK: clock_reg <= cfg_data;
                CFG_STEPS: steps_reg <= cfg_data[STEPS_W-1:0];
                CFG_WIDTH: width_reg <= cfg_data[PW_W-1:0];
                CFG_ZERO:  zero_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg   <= '0;
            tcount_reg   <= '0;
            sweep_reg    <= '0;
            prescale_reg <= '0;
            period_reg   <= '0;
            compare_reg  <= '0;
            active_reg   <= 1'b0;
        end else if (commit) begin
            prescale_reg <= pre_reg;
            period_reg   <= per_reg;
            compare_reg  <= cmp_new;
            active_reg   <= 1'b1;
        end else if (accept) begin
            case (op)
                OP_TICK: begin
                    if (active_reg) begin
                        if (pcount_reg >= prescale_reg) begin
                            pcount_reg <= '0;
                            if (tcount_reg >= period_reg) begin
                                tcount_reg <= '0;
                                sweep_reg  <= sweep_adv;
                            end else begin
                                tcount_reg <= tcount_reg + CB'(1);
                            end
                        end else begin
                            pcount_reg <= pcount_reg + CB'(1);
                        end
                    end
                end
                OP_SET_FREQ: begin
                    if (in_freq == '0) begin
                        active_reg <= 1'b0;
                    end
                end
                OP_SET_TRACK: begin
                    sweep_reg <= in_track;
                end
                OP_TRACK_ZERO: begin
                    if (zero_reg) begin
                        sweep_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (sts.freq_start) begin
            freq_reg <= in_freq;
        end
        if (cmd.div_sel == DSEL_PRE) begin
            pre_reg <= pre_calc;
        end
        if (div_done) begin
            case (cmd.div_sel)
                DSEL_RAW: raw_reg <= quo;
                DSEL_PER: per_reg <= sat(quo);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (commit || (accept && !sts.freq_start)) begin
                pend_reg <= 1'b1;
            end else if (copy) begin
                pend_reg <= 1'b0;
            end
            if (copy) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (copy) begin
            mdata_reg <= M_DATA_W'({
                active_reg,
                OUT_W'(compare_reg),
                OUT_W'(period_reg),
                OUT_W'(prescale_reg),
                trk_full[OUT_W-1:0],
                direction,
                step_out
            });
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ----- rtl/core/spsg_ctrl.sv -----
module spsg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  spsg_pkg::spsg_sts_t sts,
    output spsg_pkg::spsg_cmd_t cmd
);
    import spsg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAW,
        S_PRE,
        S_PER,
        S_WID
    } state_t;

    state_t    state_reg;
    spsg_cmd_t cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            cmd_reg.busy      <= 1'b0;
            cmd_reg.div_start <= 1'b0;
            cmd_reg.div_sel   <= DSEL_RAW;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    cmd_reg.div_start <= sts.freq_start;
                    if (sts.freq_start) begin
                        state_reg       <= S_RAW;
                        cmd_reg.busy    <= 1'b1;
                        cmd_reg.div_sel <= DSEL_RAW;
                    end
                end
                S_RAW: begin
                    cmd_reg.div_start <= 1'b0;
                    if (sts.div_done) begin
                        state_reg       <= S_PRE;
                        cmd_reg.div_sel <= DSEL_PRE;
                    end
                end
                S_PRE: begin
                    state_reg         <= S_PER;
                    cmd_reg.div_start <= 1'b1;
                    cmd_reg.div_sel   <= DSEL_PER;
                end
                S_PER: begin
                    cmd_reg.div_start <= sts.div_done;
                    if (sts.div_done) begin
                        state_reg       <= S_WID;
                        cmd_reg.div_sel <= DSEL_WID;
                    end
                end
                S_WID: begin
                    cmd_reg.div_start <= 1'b0;
                    if (sts.div_done) begin
                        state_reg    <= S_IDLE;
                        cmd_reg.busy <= 1'b0;
                    end
                end
                default: begin
                    state_reg         <= S_IDLE;
                    cmd_reg.busy      <= 1'b0;
                    cmd_reg.div_start <= 1'b0;
                end
            endcase
        end
    end

    assign cmd = cmd_reg;

endmodule

// ----- rtl/core/spsg_checker.sv -----
module spsg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [spsg_pkg::S_DATA_W-1:0] s_tdata,
    input logic [spsg_pkg::OP_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [spsg_pkg::M_DATA_W-1:0] m_tdata
);
    import spsg_pkg::*;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    a_step_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && !m_tdata[66]))
        else $error("step pulse while stopped");

    a_freq_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_SET_FREQ && s_tdata[FREQ_W-1:0] != '0)
        |=> !s_tready)
        else $error("item taken during frequency setup");

    a_compare_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[66]) |-> (m_tdata[65:50] != '0))
        else $error("running with zero compare");

endmodule

bind step_pulse_sweep_generator_top spsg_checker u_spsg_checker (.*);
